@@ rtl/rmts_pkg.sv @@
// Shared types and constants for the rate monotonic tick scheduler.
// No dependencies; used by rmts_cell and rate_monotonic_tick_scheduler_top.
package rmts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TIME_BITS = 16;
  localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // Field widths on the ports
  localparam int SLOT_IN_W   = 4;
  localparam int BUDGET_IN_W = 16;
  localparam int PERIOD_IN_W = 16;
  localparam int RUN_OUT_W   = 4;
  localparam int CNT_W       = 5;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 8;
  localparam int M_TUSER_W   = 2;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [SLOT_W-1:0]    slot_t;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    REG_ACTIVE_TASKS = 1'b0
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  // Best candidate handed down the chain
  typedef struct packed {
    logic  found;
    logic  fresh;
    slot_t slot;
    time_t period;
  } tok_t;

  typedef struct packed {
    logic  we;
    slot_t slot;
    time_t budget;
    time_t period;
  } load_t;

  typedef struct packed {
    logic  valid;
    slot_t slot;
  } commit_t;

endpackage

@@ rtl/rate_monotonic_tick_scheduler_top.sv @@
// Rate monotonic tick scheduler: a row of task slot cells plus tick sequencer.
// Instantiates rmts_cell; depends on rmts_pkg.
//
// Usage:
//   Input stream (s_axis_*): tuser is the command (load or tick). A load writes
//   one slot's budget and period; it gives no result.
//   A tick releases due slots, then a candidate walks the cell row one slot
//   per cycle, then the winner's remaining budget is decremented and one result is
//   written to the output register (m_axis_*): running slot, idle, fresh job.
//   No new item is taken while a tick is in flight; the sequencer returns to
//   idle in the same cycle that the result enters the output register.
//   APB register 0 (byte address 0): active_tasks, 5 bits, reset value 1.
//   Write it only while the block is idle.
//   Reset clears all remaining budgets and phases and sets active_tasks to 1;
//   periods and budgets hold garbage until loaded.
//   If the receiver stalls, the result waits in the output register; loads
//   are still accepted, and a following tick waits at its end until the
//   register frees.
module rate_monotonic_tick_scheduler_top import rmts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // APB configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // task_slot[3:0], exec_budget[19:4],
                                               // task_period[35:20], zero pad
  input  logic                  s_axis_tuser,  // command
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // running_task[3:0], zero pad
  output logic [M_TUSER_W-1:0]  m_axis_tuser   // idle[0], fresh_job[1]
);

  logic [CNT_W-1:0] active_q, active_d;
  state_e           state_q, state_d;
  logic             go0_q, go0_d;
  logic             m_valid_q, m_valid_d;
  logic [RUN_OUT_W-1:0] run_q, run_d;
  logic             idle_q, idle_d, fresh_q, fresh_d;

  logic             in_acc, cfg_wr, out_free, fin, tick, last_go;
  cmd_e             cmd;
  load_t            load;
  commit_t          commit;
  tok_t             final_tok;
  logic [MAX_TASKS:0] go_w;
  tok_t             tok_w [MAX_TASKS+1];
  logic [MAX_TASKS-1:0] cell_active;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    active_d = active_q;
    if (cfg_wr && (reg_idx_e'(paddr[2]) == REG_ACTIVE_TASKS)) active_d = pwdata[CNT_W-1:0];
    prdata = '0;
    if (reg_idx_e'(paddr[2]) == REG_ACTIVE_TASKS) prdata = APB_DATA_W'(active_q);
  end

  // Input side
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cmd           = cmd_e'(s_axis_tuser);
  assign tick          = in_acc && (cmd == CMD_TICK);

  always_comb begin
    load.we     = in_acc && (cmd == CMD_LOAD) &&
                  (int'(s_axis_tdata[SLOT_IN_W-1:0]) < MAX_TASKS);
    load.slot   = SLOT_W'(s_axis_tdata[SLOT_IN_W-1:0]);
    load.budget = TIME_BITS'(s_axis_tdata[SLOT_IN_W +: BUDGET_IN_W]);
    load.period = TIME_BITS'(s_axis_tdata[SLOT_IN_W+BUDGET_IN_W +: PERIOD_IN_W]);
  end

  // Cell chain
  assign go_w[0]  = go0_q;
  assign tok_w[0] = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    assign cell_active[g] = (32'(active_q) > 32'(g));
    rmts_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (SLOT_W'(g)),
      .active_i   (cell_active[g]),
      .load_i     (load),
      .tick_i     (tick),
      .commit_i   (commit),
      .go_i       (go_w[g]),
      .tok_i      (tok_w[g]),
      .go_o       (go_w[g+1]),
      .tok_o      (tok_w[g+1])
    );
  end

  assign last_go   = go_w[MAX_TASKS];
  assign final_tok = tok_w[MAX_TASKS];
  assign out_free  = !m_valid_q || m_axis_tready;

  // Sequencer
  always_comb begin
    state_d = state_q;
    go0_d   = 1'b0;
    fin     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (tick) begin
          state_d = ST_WALK;
          go0_d   = 1'b1;
        end
      end
      ST_WALK: begin
        if (last_go) begin
          if (out_free) begin
            fin     = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    commit.valid = fin && final_tok.found;
    commit.slot  = final_tok.slot;

    m_valid_d = fin || (m_valid_q && !m_axis_tready);
    run_d     = run_q;
    idle_d    = idle_q;
    fresh_d   = fresh_q;
    if (fin) begin
      run_d   = final_tok.found ? RUN_OUT_W'(final_tok.slot) : '0;
      idle_d  = !final_tok.found;
      fresh_d = final_tok.found && final_tok.fresh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= CNT_W'(1);
      state_q   <= ST_IDLE;
      go0_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      active_q  <= active_d;
      state_q   <= state_d;
      go0_q     <= go0_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    idle_q  <= idle_d;
    fresh_q <= fresh_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(run_q);
  assign m_axis_tuser  = {fresh_q, idle_q};

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input taken while a tick is in flight");

  a_single_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(go_w))
    else $error("more than one candidate in the cell chain");

  a_idle_chain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (go_w == '0))
    else $error("cell chain active while sequencer idle");
`endif

endmodule

@@ rtl/rmts_cell.sv @@
// One task slot of the scheduler chain: period, budget, remaining budget, phase.
// Compares its slot against the incoming candidate and passes the winner on.
// Depends on rmts_pkg.
module rmts_cell import rmts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  slot_t   slot_idx_i,
  input  logic    active_i,
  input  load_t   load_i,
  input  logic    tick_i,
  input  commit_t commit_i,
  input  logic    go_i,
  input  tok_t    tok_i,
  output logic    go_o,
  output tok_t    tok_o
);

  time_t period_q, period_d;
  time_t budget_q, budget_d;
  time_t remaining_q, remaining_d;
  time_t phase_q, phase_d;
  logic  go_q;
  tok_t  tok_q, tok_d;

  logic  hit_load, enabled, release_now, cand;
  time_t phase_inc, phase_next;

  always_comb begin
    hit_load    = load_i.we && (load_i.slot == slot_idx_i);
    enabled     = active_i && (period_q != '0);
    release_now = enabled && (phase_q == '0);
    phase_inc   = phase_q + time_t'(1);
    phase_next  = (phase_inc >= period_q) ? '0 : phase_inc;
    cand        = enabled && (remaining_q != '0) &&
                  (!tok_i.found || (period_q < tok_i.period));

    tok_d = tok_q;
    if (go_i) begin
      if (cand) begin
        tok_d.found  = 1'b1;
        tok_d.fresh  = (remaining_q == budget_q);
        tok_d.slot   = slot_idx_i;
        tok_d.period = period_q;
      end else begin
        tok_d = tok_i;
      end
    end

    period_d    = period_q;
    budget_d    = budget_q;
    remaining_d = remaining_q;
    phase_d     = phase_q;
    priority if (hit_load) begin
      period_d    = load_i.period;
      budget_d    = load_i.budget;
      remaining_d = '0;
      phase_d     = '0;
    end else if (tick_i) begin
      if (release_now) remaining_d = budget_q;
      if (enabled)     phase_d     = phase_next;
    end else if (commit_i.valid && (commit_i.slot == slot_idx_i)) begin
      remaining_d = remaining_q - time_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    budget_q <= budget_d;
    tok_q    <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remaining_q <= '0;
      phase_q     <= '0;
      go_q        <= 1'b0;
    end else begin
      remaining_q <= remaining_d;
      phase_q     <= phase_d;
      go_q        <= go_i;
    end
  end

  assign go_o  = go_q;
  assign tok_o = tok_q;

endmodule

@@ dv/tb_rate_monotonic_tick_scheduler_top.sv @@
`timescale 1ns / 1ps
// Testbench for rate_monotonic_tick_scheduler_top: directed and random loads/ticks,
// checked against an in-bench priority scheduler. Depends on rmts_pkg and the RTL.
module tb_rate_monotonic_tick_scheduler_top;
  import rmts_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = MAX_TASKS + 4;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    cmd_e                   cmd;
    logic [SLOT_IN_W-1:0]   slot;
    logic [BUDGET_IN_W-1:0] budget;
    logic [PERIOD_IN_W-1:0] period;
  } sched_item_t;

  typedef struct packed {
    logic [RUN_OUT_W-1:0] run;
    logic                 idle;
    logic                 fresh;
  } grant_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [M_TUSER_W-1:0]  m_axis_tuser;

  rate_monotonic_tick_scheduler_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  // Scheduler state mirrored in the bench
  time_t       period_tbl [MAX_TASKS];
  time_t       budget_tbl [MAX_TASKS];
  time_t       remain_tbl [MAX_TASKS];
  time_t       phase_tbl  [MAX_TASKS];
  logic [4:0]  active_cfg = 5'd1;

  sched_item_t pending_items[$];
  grant_t      expected_grants[$];
  sched_item_t cur_item;
  int          mismatches = 0;
  int          in_gap = 0;
  int          out_stall = 0;
  int          out_g;
  int          quiet_cycles = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;

  initial begin
    for (int k = 0; k < MAX_TASKS; k++) begin
      remain_tbl[k] = '0;
      phase_tbl[k]  = '0;
      period_tbl[k] = '0;
      budget_tbl[k] = '0;
    end
  end

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Applies one accepted item to the mirrored state; a tick yields one grant.
  task automatic schedule_item(input sched_item_t it);
    int     n;
    int     best;
    int     nxt;
    bit     found;
    grant_t g;
    if (it.cmd == CMD_LOAD) begin
      budget_tbl[it.slot] = it.budget;
      period_tbl[it.slot] = it.period;
      remain_tbl[it.slot] = '0;
      phase_tbl[it.slot]  = '0;
      return;
    end
    n     = (active_cfg > MAX_TASKS) ? MAX_TASKS : int'(active_cfg);
    found = 1'b0;
    best  = 0;
    for (int k = 0; k < n; k++)
      if (period_tbl[k] != 0 && phase_tbl[k] == 0) remain_tbl[k] = budget_tbl[k];
    // strict less-than keeps the lowest slot on equal periods
    for (int k = 0; k < n; k++) begin
      if (period_tbl[k] != 0 && remain_tbl[k] != 0) begin
        if (!found || period_tbl[k] < period_tbl[best]) begin
          found = 1'b1;
          best  = k;
        end
      end
    end
    g = '0;
    if (found) begin
      g.run   = best[RUN_OUT_W-1:0];
      g.fresh = (remain_tbl[best] == budget_tbl[best]);
      remain_tbl[best] = remain_tbl[best] - 1'b1;
    end else begin
      g.idle = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      if (period_tbl[k] != 0) begin
        nxt = int'(phase_tbl[k]) + 1;
        phase_tbl[k] = (nxt >= int'(period_tbl[k])) ? '0 : time_t'(nxt);
      end else begin
        phase_tbl[k] = '0;
      end
    end
    expected_grants = {expected_grants, g};
  endtask

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      in_gap        <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) schedule_item(cur_item);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the transaction until taken
      end else if (in_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        in_gap        <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        s_axis_tdata  <= {4'b0, cur_item.period, cur_item.budget, cur_item.slot};
        s_axis_tuser  <= cur_item.cmd;
        s_axis_tvalid <= 1'b1;
        in_gap        <= pick_gap(in_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      out_stall     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("unexpected result, running_task", m_axis_tdata[RUN_OUT_W-1:0], 0);
        end else begin
          if (m_axis_tdata[RUN_OUT_W-1:0] != expected_grants[0].run)
            report_mismatch("running_task", m_axis_tdata[RUN_OUT_W-1:0],
                            expected_grants[0].run);
          if (m_axis_tuser[0] != expected_grants[0].idle)
            report_mismatch("idle", m_axis_tuser[0], expected_grants[0].idle);
          if (m_axis_tuser[1] != expected_grants[0].fresh)
            report_mismatch("fresh_job", m_axis_tuser[1], expected_grants[0].fresh);
          void'(expected_grants.pop_front());
        end
      end
      if (out_stall != 0) begin
        m_axis_tready <= 1'b0;
        out_stall     <= out_stall - 1;
      end else begin
        out_g = pick_gap(out_calm);
        if (out_g == 0) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          out_stall     <= out_g - 1;
        end
      end
    end
  end

  // Watchdog on stretches without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[rate_monotonic_tick_scheduler_top] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_item(input cmd_e c, input int slot, input int budget, input int period);
    sched_item_t it;
    it.cmd    = c;
    it.slot   = slot[SLOT_IN_W-1:0];
    it.budget = budget[BUDGET_IN_W-1:0];
    it.period = period[PERIOD_IN_W-1:0];
    pending_items = {pending_items, it};
  endtask

  task automatic drain_and_settle();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_grants.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_active(input logic [4:0] v);
    bit ok;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(REG_ACTIVE_TASKS));
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = pready;
      @(posedge clk_i);
    end while (!ok);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    active_cfg = v;
  endtask

  initial begin
    int cfg_list[$];
    int slot;
    int budget;
    int period;
    int r;
    cfg_list = '{16, 0, 31, 1, 8, 17, 3, 12, 5, 15, 0, 0};
    cfg_list[10] = $urandom_range(2, 15);
    cfg_list[11] = $urandom_range(16, 31);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset config: one slot active; fresh job, budget run-out and idle tick
    queue_item(CMD_LOAD, 0, 2, 3);
    repeat (4) queue_item(CMD_TICK, 15, 16'hFFFF, 16'hFFFF);
    queue_item(CMD_LOAD, 1, 0, 4);              // zero budget never runs
    queue_item(CMD_LOAD, 2, 5, 0);              // period 0 disables the slot
    queue_item(CMD_LOAD, 3, 3, 2);              // overloaded slot
    queue_item(CMD_LOAD, 4, 1, 1);              // shortest period, runs each tick
    for (int k = 5; k < 15; k++) queue_item(CMD_LOAD, k, k % 3 + 1, k + 3);
    queue_item(CMD_LOAD, 15, 16'hFFFF, 16'hFFFF);
    drain_and_settle();
    write_active(5'd16);
    @(negedge clk_i);
    repeat (4) queue_item(CMD_TICK, 0, 0, 0);

    foreach (cfg_list[p]) begin
      drain_and_settle();
      write_active(cfg_list[p][4:0]);
      @(negedge clk_i);
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 80) begin
          queue_item(CMD_TICK, $urandom_range(0, 15), $urandom, $urandom);
        end else begin
          slot = $urandom_range(0, 15);
          r    = $urandom_range(0, 9);
          if (r == 0) begin
            period = $urandom_range(0, 65535);
            budget = $urandom_range(0, 65535);
          end else if (r == 1) begin
            period = $urandom_range(0, 1) ? 65535 : 0;
            budget = $urandom_range(0, 1) ? 65535 : 0;
          end else begin
            period = $urandom_range(1, 24);
            budget = $urandom_range(0, period / 2 + 1);
          end
          queue_item(CMD_LOAD, slot, budget, period);
        end
      end
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("[rate_monotonic_tick_scheduler_top] OK");
    end else begin
      $display("[rate_monotonic_tick_scheduler_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rmts_pkg.sv
rtl/rmts_cell.sv
rtl/rate_monotonic_tick_scheduler_top.sv
dv/tb_rate_monotonic_tick_scheduler_top.sv
